FILE: rtl/core/ring_neighbour_ticket_arbiter_defines.svh
// Assertion macros for the ring seat arbiter.
`ifndef RING_NEIGHBOUR_TICKET_ARBITER_DEFINES_SVH
`define RING_NEIGHBOUR_TICKET_ARBITER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define RNTA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define RNTA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RNTA_ASSERT(name, clk, rst, prop, msg)
`define RNTA_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/core/rnta_pkg.sv
`timescale 1ns / 1ps

package rnta_pkg;

   // Field widths fixed by the channel definitions
   localparam int SEAT_IO_W = 4;
   localparam int CFG_W     = 5;
   localparam int TICKET_W  = 32;

   // Defaults and reset values
   localparam int DEF_MAX_SEATS = 16;
   localparam logic [CFG_W-1:0] RESET_SEATS = CFG_W'(5);

   // Command queue depth between front and back
   localparam int Q_DEPTH = 2;

   // Operation codes
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REQ_EVAL,
      ST_REL_LEFT,
      ST_REL_RIGHT,
      ST_REL_EMIT
   } state_type;

   // One grant transaction on the result channel
   typedef struct packed {
      logic [SEAT_IO_W-1:0] granted_seat;
      logic                 last;
   } rsp_type;

   // A neighbour's ticket is older when the wrapped difference is negative
   function automatic logic older(input logic [TICKET_W-1:0] nb,
                                  input logic [TICKET_W-1:0] mine);
      logic [TICKET_W-1:0] diff;
      diff = nb - mine;
      return diff[TICKET_W-1];
   endfunction

endpackage

FILE: rtl/core/rnta_queue.sv
`timescale 1ns / 1ps

module rnta_queue
   import rnta_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head_data
);

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/rnta_front.sv
`timescale 1ns / 1ps

module rnta_front
   import rnta_pkg::*;
#(
   parameter int MAX_SEATS = DEF_MAX_SEATS,
   parameter int SEAT_W    = $clog2(MAX_SEATS),
   parameter int CMD_W     = 1 + 5 * SEAT_W
) (
   input  logic                 req_start,
   input  logic                 req_op,
   input  logic [SEAT_IO_W-1:0] req_seat,
   input  logic [CFG_W-1:0]     seats_in_use,
   input  logic                 q_full,
   output logic                 q_push,
   output logic [CMD_W-1:0]     q_cmd
);

   localparam int RING_RAW = $clog2(MAX_SEATS + 1);
   localparam int RING_W   = (RING_RAW > CFG_W) ? RING_RAW : CFG_W;

   logic [RING_W-1:0] cfg_ext;
   logic [RING_W-1:0] ring_n;
   logic [RING_W-1:0] seat_ext;
   logic [RING_W-1:0] left_ext;
   logic [RING_W-1:0] left2_ext;
   logic [RING_W-1:0] right_ext;
   logic [RING_W-1:0] right2_ext;
   logic              in_range;

   // Clamp the ring size to between two and the seats that exist
   assign cfg_ext = RING_W'(seats_in_use);
   always_comb begin
      if (cfg_ext < RING_W'(2)) begin
         ring_n = RING_W'(2);
      end else if (cfg_ext > RING_W'(MAX_SEATS)) begin
         ring_n = RING_W'(MAX_SEATS);
      end else begin
         ring_n = cfg_ext;
      end
   end

   // Drop seats off the ring; find both neighbours and theirs
   assign seat_ext   = RING_W'(req_seat);
   assign in_range   = (seat_ext < ring_n);
   assign left_ext   = (seat_ext == '0) ? ring_n - RING_W'(1) : seat_ext - RING_W'(1);
   assign left2_ext  = (left_ext == '0) ? ring_n - RING_W'(1) : left_ext - RING_W'(1);
   assign right_ext  = (seat_ext == ring_n - RING_W'(1)) ? '0 : seat_ext + RING_W'(1);
   assign right2_ext = (right_ext == ring_n - RING_W'(1)) ? '0 : right_ext + RING_W'(1);

   assign q_push = req_start && !q_full && in_range;
   assign q_cmd  = {req_op, SEAT_W'(seat_ext), SEAT_W'(left_ext), SEAT_W'(left2_ext),
                    SEAT_W'(right_ext), SEAT_W'(right2_ext)};

endmodule

FILE: rtl/core/rnta_back.sv
`timescale 1ns / 1ps
`include "ring_neighbour_ticket_arbiter_defines.svh"

module rnta_back
   import rnta_pkg::*;
#(
   parameter int MAX_SEATS = DEF_MAX_SEATS,
   parameter int SEAT_W    = $clog2(MAX_SEATS),
   parameter int CMD_W     = 1 + 5 * SEAT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  logic [CMD_W-1:0] q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   output rsp_type          rsp
);

   state_type state_ff, state_in;

   // Queue head fields
   logic              h_op;
   logic [SEAT_W-1:0] h_seat, h_left, h_left2, h_right, h_right2;

   // Command held while it is carried out
   logic [SEAT_W-1:0] cmd_seat_ff, cmd_left_ff, cmd_left2_ff, cmd_right_ff, cmd_right2_ff;

   // Seat phases: one hungry and one eating bit per seat
   logic [MAX_SEATS-1:0] hungry_ff;
   logic [MAX_SEATS-1:0] eating_ff;

   // Ticket store; entries are only compared once the seat is hungry
   logic [TICKET_W-1:0] ticket_mem [MAX_SEATS];
   logic [TICKET_W-1:0] rd_a_ff, rd_b_ff;
   logic [SEAT_W-1:0]   rd_addr_a, rd_addr_b;
   logic                mem_we;
   logic [TICKET_W-1:0] counter_ff;
   logic [TICKET_W-1:0] ticket_ff;

   // Phase update controls
   logic [SEAT_W-1:0] ph_idx;
   logic              ph_mark_hungry, ph_drop_eating, ph_grant;

   logic pend_left_ff, pend_set, pend_clr;
   logic start_req, start_rel;
   logic ok_req, ok_left, ok_right;

   logic              out_fire, out_last;
   logic [SEAT_W-1:0] out_idx;
   logic              rsp_valid_ff;
   logic [SEAT_W-1:0] rsp_seat_ff;
   logic              rsp_last_ff;

   // Unpack the queue head
   assign h_right2 = q_cmd[SEAT_W-1:0];
   assign h_right  = q_cmd[2*SEAT_W-1:SEAT_W];
   assign h_left2  = q_cmd[3*SEAT_W-1:2*SEAT_W];
   assign h_left   = q_cmd[4*SEAT_W-1:3*SEAT_W];
   assign h_seat   = q_cmd[5*SEAT_W-1:4*SEAT_W];
   assign h_op     = q_cmd[5*SEAT_W];

   // Classify the head against the current seat phase
   assign start_req = q_valid && (h_op == OP_REQUEST) && !hungry_ff[h_seat]
                      && !eating_ff[h_seat];
   assign start_rel = q_valid && (h_op == OP_RELEASE) && eating_ff[h_seat];

   // Grant checks; the released seat is thinking and never blocks
   assign ok_req = !eating_ff[cmd_left_ff] && !eating_ff[cmd_right_ff]
                   && !(hungry_ff[cmd_left_ff] && older(rd_a_ff, ticket_ff))
                   && !(hungry_ff[cmd_right_ff] && older(rd_b_ff, ticket_ff));
   assign ok_left = hungry_ff[cmd_left_ff] && !eating_ff[cmd_left2_ff]
                    && !(hungry_ff[cmd_left2_ff] && older(rd_b_ff, rd_a_ff));
   assign ok_right = hungry_ff[cmd_right_ff] && !eating_ff[cmd_right2_ff]
                     && !(hungry_ff[cmd_right2_ff] && older(rd_b_ff, rd_a_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_req) begin
               state_in = ST_REQ_EVAL;
            end else if (start_rel) begin
               state_in = ST_REL_LEFT;
            end
         end
         ST_REQ_EVAL:  state_in = ST_IDLE;
         ST_REL_LEFT:  state_in = ST_REL_RIGHT;
         ST_REL_RIGHT: state_in = (pend_left_ff && ok_right) ? ST_REL_EMIT : ST_IDLE;
         ST_REL_EMIT:  state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      q_pop          = 1'b0;
      rd_addr_a      = cmd_right_ff;
      rd_addr_b      = cmd_right2_ff;
      mem_we         = 1'b0;
      ph_idx         = cmd_seat_ff;
      ph_mark_hungry = 1'b0;
      ph_drop_eating = 1'b0;
      ph_grant       = 1'b0;
      pend_set       = 1'b0;
      pend_clr       = 1'b0;
      out_fire       = 1'b0;
      out_idx        = cmd_right_ff;
      out_last       = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop          = q_valid;
            rd_addr_a      = h_left;
            rd_addr_b      = (h_op == OP_RELEASE) ? h_left2 : h_right;
            mem_we         = start_req;
            ph_idx         = h_seat;
            ph_mark_hungry = start_req;
            ph_drop_eating = start_rel;
         end
         ST_REQ_EVAL: begin
            ph_idx   = cmd_seat_ff;
            ph_grant = ok_req;
            out_fire = ok_req;
            out_idx  = cmd_seat_ff;
         end
         ST_REL_LEFT: begin
            ph_idx   = cmd_left_ff;
            ph_grant = ok_left;
            pend_set = ok_left;
         end
         ST_REL_RIGHT: begin
            ph_idx   = cmd_right_ff;
            ph_grant = ok_right;
            pend_clr = 1'b1;
            if (pend_left_ff) begin
               out_fire = 1'b1;
               out_idx  = cmd_left_ff;
               out_last = !ok_right;
            end else begin
               out_fire = ok_right;
            end
         end
         ST_REL_EMIT: begin
            out_fire = 1'b1;
         end
         default: begin
            out_fire = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hungry_ff    <= '0;
         eating_ff    <= '0;
         counter_ff   <= '0;
         pend_left_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= out_fire;
         if (ph_mark_hungry) begin
            hungry_ff[ph_idx] <= 1'b1;
         end
         if (ph_drop_eating) begin
            eating_ff[ph_idx] <= 1'b0;
         end
         if (ph_grant) begin
            hungry_ff[ph_idx] <= 1'b0;
            eating_ff[ph_idx] <= 1'b1;
         end
         if (start_req && state_ff == ST_IDLE) begin
            counter_ff <= counter_ff + TICKET_W'(1);
         end
         if (pend_set) begin
            pend_left_ff <= 1'b1;
         end else if (pend_clr) begin
            pend_left_ff <= 1'b0;
         end
      end
   end

   // Hold the command and the new ticket
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_seat_ff   <= h_seat;
         cmd_left_ff   <= h_left;
         cmd_left2_ff  <= h_left2;
         cmd_right_ff  <= h_right;
         cmd_right2_ff <= h_right2;
         ticket_ff     <= counter_ff;
      end
      rsp_seat_ff <= out_idx;
      rsp_last_ff <= out_last;
   end

   // Ticket memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ticket_mem[h_seat] <= counter_ff;
      end
      rd_a_ff <= ticket_mem[rd_addr_a];
      rd_b_ff <= ticket_mem[rd_addr_b];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp.granted_seat  = SEAT_IO_W'(rsp_seat_ff);
   assign rsp.last          = rsp_last_ff;

   `RNTA_ASSERT(a_phase_exclusive, clock, reset, (hungry_ff & eating_ff) == '0, "seat hungry and eating")
   `RNTA_ASSERT(a_grant_eats, clock, reset, !rsp_valid_ff || eating_ff[rsp_seat_ff], "granted seat not eating")
   `RNTA_ASSERT(a_pend_in_right, clock, reset, !pend_left_ff || state_ff == ST_REL_RIGHT, "left grant pending off sequence")
   `RNTA_ASSERT(a_ticket_step, clock, reset, state_ff != ST_REQ_EVAL || counter_ff == ticket_ff + TICKET_W'(1), "ticket counter out of step")
   `RNTA_ASSERT_NEXT(a_emit_last, clock, reset, state_ff == ST_REL_EMIT, rsp_valid_ff && rsp_last_ff, "second grant not last")

endmodule

FILE: rtl/core/ring_neighbour_ticket_arbiter.sv
`timescale 1ns / 1ps

// Ticket arbiter for seats on a ring; neighbouring seats never eat together.
// Request channel: drive req_op (request or release) and req_seat with
// req_start; the transaction is taken on an edge where req_busy is low.
// Transactions for seats off the ring, requests from seats that are not
// thinking and releases from seats that are not eating are taken and dropped.
// Each grant appears for one cycle on rsp_granted_seat with rsp_strobe high;
// rsp_last marks the final grant of a transaction. There is no back-pressure:
// the receiver must take every strobe.
// A grant is registered before it strobes. The back sequencer holds one
// command at a time: a dropped command leaves in the idle state, a request
// goes on to the evaluation state, a release to the left and right check
// states and, when both neighbours are granted, an emit state. Each check
// uses two reads of the ticket memory.
// A two-entry command queue takes new transactions while the back works.
// csr_data sets the ring size; csr_ready is always high; write it only idle.
// Synchronous reset: all seats thinking, ticket counter zero, ring size five,
// queue empty. No clearing pass is needed after reset.

module ring_neighbour_ticket_arbiter
   import rnta_pkg::*;
#(
   parameter int MAX_SEATS = DEF_MAX_SEATS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   output logic                 req_busy,
   input  logic                 req_op,
   input  logic [SEAT_IO_W-1:0] req_seat,
   output logic                 rsp_strobe,
   output logic [SEAT_IO_W-1:0] rsp_granted_seat,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int SEAT_W = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
   localparam int CMD_W  = 1 + 5 * SEAT_W;

   logic [CFG_W-1:0] seats_in_use_ff;
   logic             q_push, q_full, q_pop, q_valid;
   logic [CMD_W-1:0] push_cmd, head_cmd;
   rsp_type          rsp;

   // Hold the ring size register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         seats_in_use_ff <= RESET_SEATS;
      end else if (csr_valid && csr_ready) begin
         seats_in_use_ff <= csr_data;
      end
   end

   assign req_busy = q_full;

   rnta_front #(
      .MAX_SEATS (MAX_SEATS),
      .SEAT_W    (SEAT_W),
      .CMD_W     (CMD_W)
   ) u_front (
      .req_start    (req_start),
      .req_op       (req_op),
      .req_seat     (req_seat),
      .seats_in_use (seats_in_use_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (push_cmd)
   );

   rnta_queue #(
      .DATA_W (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_data (head_cmd)
   );

   rnta_back #(
      .MAX_SEATS (MAX_SEATS),
      .SEAT_W    (SEAT_W),
      .CMD_W     (CMD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_strobe),
      .rsp       (rsp)
   );

   assign rsp_granted_seat = rsp.granted_seat;
   assign rsp_last         = rsp.last;

endmodule
